@@ design/bsmh_pkg.sv @@
// Package for the byte stream mix hash: widths, constants and controller-to-datapath command type.
package bsmh_pkg;

  localparam int unsigned HASH_W = 32;
  localparam int unsigned BYTE_W = 7;
  localparam int unsigned POS_W  = 4;

  localparam logic [HASH_W-1:0] INIT_HASH = 32'h1234_5678;
  localparam logic [HASH_W-1:0] MIX_MUL_A = 32'h85eb_ca6b;
  localparam logic [HASH_W-1:0] MIX_MUL_B = 32'hc2b2_ae35;

  // First 16 SHA-256 round constants, picked by position
  localparam logic [HASH_W-1:0] ROUND_WORDS [16] = '{
    32'h428a_2f98, 32'h7137_4491, 32'hb5c0_fbcf, 32'he9b5_dba5,
    32'h3956_c25b, 32'h59f1_11f1, 32'h923f_82a4, 32'hab1c_5ed5,
    32'hd807_aa98, 32'h1283_5b01, 32'h2431_85be, 32'h550c_7dc3,
    32'h72be_5d74, 32'h80de_b1fe, 32'h9bdc_06a7, 32'hc19b_f174
  };

  // Commands from controller to datapath
  typedef struct packed {
    logic absorb;    // fold the input byte into the running hash
    logic fin_mul_a; // xorshift 16, multiply A; reset running state
    logic fin_mul_b; // xorshift 13, multiply B
    logic load_out;  // xorshift 16 into the output register
  } dp_cmd_t;

endpackage

@@ design/byte_stream_mix_hash.sv @@
// Top level of the byte stream mix hash: controller and datapath.
// Hashes a string that arrives one 7-bit character per word. A word without
// last is absorbed as it is accepted. A word with last is accepted, then
// passes two registered 32x32 multiply steps of the fmix32 finalizer and one
// output step. in_stall_o is high through these steps after the accept, and
// longer while the previous hash still waits in the output register. The
// 32-bit hash is then held in the output register until taken, while the next
// string's words are already accepted. A word with byte_present low only
// finalizes (if last).
module byte_stream_mix_hash (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [bsmh_pkg::BYTE_W-1:0] data_byte_i,
  input  logic                        byte_present_i,
  input  logic                        last_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [bsmh_pkg::HASH_W-1:0] hash_value_o
);
  import bsmh_pkg::*;

  dp_cmd_t cmd;

  bsmh_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .byte_present_i (byte_present_i),
    .last_i         (last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .cmd_o          (cmd)
  );

  bsmh_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .data_byte_i  (data_byte_i),
    .hash_value_o (hash_value_o)
  );

endmodule

@@ design/bsmh_dp.sv @@
// Datapath of the byte stream mix hash: running state, finalizer and output register.
module bsmh_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bsmh_pkg::dp_cmd_t             cmd_i,
  input  logic [bsmh_pkg::BYTE_W-1:0]   data_byte_i,
  output logic [bsmh_pkg::HASH_W-1:0]   hash_value_o
);
  import bsmh_pkg::*;

  logic [HASH_W-1:0] hash_q, hash_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [HASH_W-1:0] work_q, work_d;
  logic [HASH_W-1:0] out_q, out_d;

  logic [HASH_W-1:0] mixed;
  logic [HASH_W-1:0] xs16_hash;
  logic [HASH_W-1:0] xs13_work;

  // One absorb step: xor shifted byte, rotate left 5, xor round word
  always_comb begin
    mixed = hash_q ^ (HASH_W'(data_byte_i) << {pos_q[1:0], 3'b000});
    mixed = {mixed[HASH_W-6:0], mixed[HASH_W-1:HASH_W-5]};
    mixed = mixed ^ ROUND_WORDS[pos_q];
  end

  assign xs16_hash = hash_q ^ (hash_q >> 16);
  assign xs13_work = work_q ^ (work_q >> 13);

  // Next state of running hash, position, finalizer work word and output word
  always_comb begin
    hash_d = hash_q;
    pos_d  = pos_q;
    work_d = work_q;
    out_d  = out_q;
    if (cmd_i.absorb) begin
      hash_d = mixed;
      pos_d  = pos_q + POS_W'(1);
    end
    if (cmd_i.fin_mul_a) begin
      work_d = xs16_hash * MIX_MUL_A;
      hash_d = INIT_HASH;
      pos_d  = '0;
    end
    if (cmd_i.fin_mul_b) begin
      work_d = xs13_work * MIX_MUL_B;
    end
    if (cmd_i.load_out) begin
      out_d = work_q ^ (work_q >> 16);
    end
  end

  // Running state resets; work and output words are payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= INIT_HASH;
      pos_q  <= '0;
    end else begin
      hash_q <= hash_d;
      pos_q  <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    out_q  <= out_d;
  end

  assign hash_value_o = out_q;

endmodule

@@ design/bsmh_ctrl.sv @@
// Controller of the byte stream mix hash: input handshake, finalizer sequencing, output valid.
module bsmh_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              byte_present_i,
  input  logic              last_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bsmh_pkg::dp_cmd_t cmd_o
);
  import bsmh_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MULA,
    ST_MULB,
    ST_FIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_acc;
  logic   out_free;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Next state and datapath commands
  always_comb begin
    state_d          = state_q;
    out_valid_d      = out_valid_q && out_stall_i;
    cmd_o            = '0;
    cmd_o.absorb     = in_acc && byte_present_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && last_i) begin
          state_d = ST_MULA;
        end
      end
      ST_MULA: begin
        cmd_o.fin_mul_a = 1'b1;
        state_d         = ST_MULB;
      end
      ST_MULB: begin
        cmd_o.fin_mul_b = 1'b1;
        state_d         = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A last word starts the finalizer and blocks input next cycle
  a_last_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_i) |=> (state_q == ST_MULA))
    else $error("last word did not start finalization");

  // The two multiply steps follow each other
  a_mul_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MULA) |=> (state_q == ST_MULB))
    else $error("multiply B did not follow multiply A");

  // A new result appears only out of the final step
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FIN))
    else $error("output valid rose outside the final step");

  // The output register is never overwritten while stalled
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> out_free)
    else $error("result overwritten while waiting");

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for byte_stream_mix_hash: directed and random strings.
`timescale 1ns / 100ps

module tb;
  import bsmh_pkg::*;

  localparam int unsigned IDLE_LIMIT = 2000; // cycles without any handshake
  localparam int unsigned DRAIN_WAIT = 20;   // extra wait after the last hash is taken
  localparam int unsigned PHASE_CHARS = 190; // ~850 words over four phases

  typedef struct packed {
    logic [BYTE_W-1:0] ch;
    logic              pres;
    logic              lst;
  } str_word_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [BYTE_W-1:0] data_byte_i = '0;
  logic              byte_present_i = 1'b0;
  logic              last_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [HASH_W-1:0] hash_value_o;

  // Predicted string state and hashes still to come out
  logic [HASH_W-1:0] run_hash = INIT_HASH;
  logic [POS_W-1:0]  char_pos = '0;
  logic [HASH_W-1:0] hash_q[$];

  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;
  int unsigned err_cnt = 0;
  int unsigned quiet_cycles = 0;

  // Directed strings: an empty string, words with nothing, extreme characters,
  // a zero character mid-string, a finalize-only word, and a 17 character
  // string so the position counter wraps
  str_word_t dir_words[25] = '{
    '{7'h00, 1'b0, 1'b1},
    '{7'h55, 1'b0, 1'b0},
    '{7'h7f, 1'b1, 1'b1},
    '{7'h00, 1'b1, 1'b1},
    '{7'h41, 1'b1, 1'b0},
    '{7'h00, 1'b1, 1'b0},
    '{7'h2a, 1'b0, 1'b0},
    '{7'h7f, 1'b0, 1'b1},
    '{7'h7f, 1'b1, 1'b0}, '{7'h00, 1'b1, 1'b0}, '{7'h01, 1'b1, 1'b0},
    '{7'h40, 1'b1, 1'b0}, '{7'h2a, 1'b1, 1'b0}, '{7'h55, 1'b1, 1'b0},
    '{7'h7f, 1'b1, 1'b0}, '{7'h7f, 1'b1, 1'b0}, '{7'h00, 1'b1, 1'b0},
    '{7'h00, 1'b1, 1'b0}, '{7'h61, 1'b1, 1'b0}, '{7'h7a, 1'b1, 1'b0},
    '{7'h30, 1'b1, 1'b0}, '{7'h39, 1'b1, 1'b0}, '{7'h20, 1'b1, 1'b0},
    '{7'h7e, 1'b1, 1'b0}, '{7'h5a, 1'b1, 1'b1}
  };

  byte_stream_mix_hash i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .byte_present_i(byte_present_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .hash_value_o  (hash_value_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Fold one character into the hash at the given string position
  function automatic logic [HASH_W-1:0] mix_char(logic [HASH_W-1:0] h,
                                                 logic [BYTE_W-1:0] ch,
                                                 logic [POS_W-1:0] pos);
    logic [HASH_W-1:0] t;
    t = h ^ ({{(HASH_W-BYTE_W){1'b0}}, ch} << {pos[1:0], 3'b000});
    t = {t[HASH_W-6:0], t[HASH_W-1:HASH_W-5]};
    return t ^ ROUND_WORDS[pos];
  endfunction

  // fmix32 finalizer
  function automatic logic [HASH_W-1:0] fmix32(logic [HASH_W-1:0] h);
    logic [HASH_W-1:0] t;
    t = h ^ (h >> 16);
    t = t * MIX_MUL_A;
    t = t ^ (t >> 13);
    t = t * MIX_MUL_B;
    return t ^ (t >> 16);
  endfunction

  // Update the predicted state for one accepted word
  task automatic hash_word(input str_word_t w);
    if (w.pres) begin
      run_hash = mix_char(run_hash, w.ch, char_pos);
      char_pos = char_pos + 1'b1;
    end
    if (w.lst) begin
      hash_q.push_back(fmix32(run_hash));
      run_hash = INIT_HASH;
      char_pos = '0;
    end
  endtask

  // Drive one word, starting and ending at a falling edge
  task automatic send_word(input str_word_t w);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      data_byte_i <= BYTE_W'($urandom);
      byte_present_i <= 1'($urandom);
      last_i <= 1'($urandom);
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= w.ch;
    byte_present_i <= w.pres;
    last_i <= w.lst;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    hash_word(w);
    @(negedge clk_i);
  endtask

  function automatic str_word_t rand_word(logic pres, logic lst);
    str_word_t w;
    w.ch = BYTE_W'($urandom);
    w.pres = pres;
    w.lst = lst;
    return w;
  endfunction

  // Receiver stall
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_stall_pct);
  end

  // Compare each taken hash against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (hash_q.size() == 0) begin
        $display("%0t: unexpected hash, expected none, got %08h", $time, hash_value_o);
        err_cnt++;
      end else begin
        if (hash_value_o !== hash_q[0]) begin
          $display("%0t: hash mismatch, expected %08h, got %08h",
                   $time, hash_q[0], hash_value_o);
          err_cnt++;
        end
        void'(hash_q.pop_front());
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("byte_stream_mix_hash regression: fail");
      $finish;
    end
  end

  initial begin
    int unsigned chars;
    int unsigned len;
    int unsigned kind;
    bit          sep_fin;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed strings, no idling
    foreach (dir_words[i]) send_word(dir_words[i]);

    // Random strings in four idling phases
    for (int ph = 0; ph < 4; ph++) begin
      unique case (ph)
        0: begin
          in_idle_pct = 0;
          out_stall_pct = 0;
        end
        1: begin
          in_idle_pct = 88;
          out_stall_pct = 0;
        end
        2: begin
          in_idle_pct = 0;
          out_stall_pct = 88;
        end
        default: begin
          in_idle_pct = 9;
          out_stall_pct = 9;
        end
      endcase
      chars = 0;
      while (chars < PHASE_CHARS) begin
        kind = $urandom_range(99);
        if (kind < 6) begin
          // empty string
          send_word(rand_word(1'b0, 1'b1));
          chars++;
        end else begin
          len = (kind < 16) ? $urandom_range(13, 40) : $urandom_range(1, 12);
          sep_fin = ($urandom_range(99) < 20);
          for (int unsigned k = 0; k < len; k++) begin
            // stray word carrying nothing
            if ($urandom_range(99) < 5) send_word(rand_word(1'b0, 1'b0));
            send_word(rand_word(1'b1, (k == len - 1) && !sep_fin));
            chars++;
          end
          if (sep_fin) send_word(rand_word(1'b0, 1'b1));
        end
      end
    end
    in_valid_i <= 1'b0;

    // Drain outstanding hashes, then let the design settle
    while (hash_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("byte_stream_mix_hash regression: pass");
    end else begin
      $display("byte_stream_mix_hash regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/bsmh_pkg.sv
design/bsmh_dp.sv
design/bsmh_ctrl.sv
design/byte_stream_mix_hash.sv
verif/tb.sv
